// File: rtl/efr_pkg.sv
// ----------------------------------------------------------------------------
// efr_pkg
// Shared types and constants for the escaped frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package efr_pkg;

   localparam int FILL_W    = 8;
   localparam int INDEX_W   = 7;
   localparam int LENGTH_W  = 16;
   localparam int COUNT_W   = 32;

   localparam logic [7:0] DELIM_BYTE = 8'h7E;
   localparam logic [7:0] ESC_BYTE   = 8'h7D;
   localparam logic [7:0] ESC_XOR    = 8'h20;
   localparam logic [7:0] SUM_BASE   = 8'hFF;

   typedef enum logic [2:0] {
      EV_NONE     = 3'd0,
      EV_GOOD     = 3'd1,
      EV_BAD      = 3'd2,
      EV_OVERFLOW = 3'd3,
      EV_RESTART  = 3'd4
   } event_type;

   typedef struct packed {
      logic [7:0]          data_byte;
      logic                stored_flag;
      logic [INDEX_W-1:0]  byte_index;
      logic [LENGTH_W-1:0] frame_length;
      event_type           event_res;
      logic [COUNT_W-1:0]  bytes_received;
      logic [COUNT_W-1:0]  bytes_dropped;
      logic [COUNT_W-1:0]  frames_good;
      logic [COUNT_W-1:0]  frames_bad;
   } result_type;

endpackage

`default_nettype wire

// File: rtl/escaped_frame_receiver.sv
// ----------------------------------------------------------------------------
// escaped_frame_receiver
// Byte-stuffed frame receiver with checksum check and running counters.
//
// Input channel (req_): one raw serial byte per beat. Result channel (rsp_):
// exactly one result beat per input beat, in order, carrying the unescaped
// stored byte, its index, the header length, an event code and the four
// counters as they stand after that byte.
// A beat moves when valid is high and stall is low.
// Result path: the result for an accepted byte is registered in the result
// register, or in the skid entry while that register holds a stalled beat.
// Throughput: one byte per cycle while req_stall is low; the decode of a byte
// is a single pass of compare, 8-bit add and counter increment between the frame state and the result register.
// Stall: a result register plus one skid entry absorb a stalled receiver;
// req_stall rises only once both are full and falls when a result leaves.
// Reset (synchronous): the receiver returns to hunting for a delimiter, all
// counters clear and no result is pending.
// ----------------------------------------------------------------------------
`default_nettype none

module escaped_frame_receiver
   import efr_pkg::*;
#(
   parameter int BUFFER_BYTES = 128
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [7:0]          req_rx_byte,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [7:0]               rsp_data_byte,
   output logic                     rsp_stored_flag,
   output logic [INDEX_W-1:0]       rsp_byte_index,
   output logic [LENGTH_W-1:0]      rsp_frame_length,
   output logic [2:0]               rsp_event_res,
   output logic [COUNT_W-1:0]       rsp_bytes_received,
   output logic [COUNT_W-1:0]       rsp_bytes_dropped,
   output logic [COUNT_W-1:0]       rsp_frames_good,
   output logic [COUNT_W-1:0]       rsp_frames_bad
);

   result_type step_res, out_res;
   logic       accept;

   assign accept = req_valid && !req_stall;

   efr_core #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_rx_byte),
      .result  (step_res)
   );

   efr_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_data   (step_res),
      .in_stall  (req_stall),
      .out_valid (rsp_valid),
      .out_data  (out_res),
      .out_stall (rsp_stall)
   );

   assign rsp_data_byte      = out_res.data_byte;
   assign rsp_stored_flag    = out_res.stored_flag;
   assign rsp_byte_index     = out_res.byte_index;
   assign rsp_frame_length   = out_res.frame_length;
   assign rsp_event_res      = out_res.event_res;
   assign rsp_bytes_received = out_res.bytes_received;
   assign rsp_bytes_dropped  = out_res.bytes_dropped;
   assign rsp_frames_good    = out_res.frames_good;
   assign rsp_frames_bad     = out_res.frames_bad;

endmodule

`default_nettype wire

// File: rtl/efr_core.sv
// ----------------------------------------------------------------------------
// efr_core
// Frame state and per-beat decode: delimiter, escape, length, checksum,
// counters. Produces the result for the current byte combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module efr_core
   import efr_pkg::*;
#(
   parameter int BUFFER_BYTES = 128
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] rx_byte,
   output result_type      result
);

   localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(BUFFER_BYTES);

   logic [FILL_W-1:0]   fill_count_ff, fill_count_in;
   logic                escape_pending_ff, escape_pending_in;
   logic [LENGTH_W-1:0] length_word_ff, length_word_in;
   logic [7:0]          payload_sum_ff, payload_sum_in;
   logic [COUNT_W-1:0]  received_ff, received_in;
   logic [COUNT_W-1:0]  discarded_ff, discarded_in;
   logic [COUNT_W-1:0]  good_ff, good_in;
   logic [COUNT_W-1:0]  bad_ff, bad_in;

   logic [7:0]          d;
   logic [FILL_W-1:0]   pay_pos;
   event_type           ev;

   always_comb begin
      fill_count_in     = fill_count_ff;
      escape_pending_in = escape_pending_ff;
      length_word_in    = length_word_ff;
      payload_sum_in    = payload_sum_ff;
      received_in       = received_ff + COUNT_W'(1);
      discarded_in      = discarded_ff;
      good_in           = good_ff;
      bad_in            = bad_ff;
      d                 = escape_pending_ff ? (rx_byte ^ ESC_XOR) : rx_byte;
      pay_pos           = fill_count_ff - FILL_W'(3);
      ev                = EV_NONE;
      result            = '0;

      if (rx_byte == DELIM_BYTE) begin
         if (fill_count_ff != '0) begin
            discarded_in = discarded_ff + COUNT_W'(fill_count_ff);
            ev           = EV_RESTART;
         end
         fill_count_in      = FILL_W'(1);
         escape_pending_in  = 1'b0;
         length_word_in     = '0;
         payload_sum_in     = '0;
         result.data_byte   = rx_byte;
         result.stored_flag = 1'b1;
      end else if (fill_count_ff == '0) begin
         discarded_in = discarded_ff + COUNT_W'(1);
      end else if (!escape_pending_ff && rx_byte == ESC_BYTE) begin
         escape_pending_in = 1'b1;
         if (fill_count_ff >= FILL_W'(3)) begin
            result.frame_length = length_word_ff;
         end
      end else begin
         escape_pending_in = 1'b0;
         if (fill_count_ff >= FILL_MAX) begin
            discarded_in      = discarded_ff + COUNT_W'(fill_count_ff) + COUNT_W'(1);
            ev                = EV_OVERFLOW;
            fill_count_in     = '0;
            length_word_in    = '0;
            payload_sum_in    = '0;
         end else begin
            result.byte_index  = fill_count_ff[INDEX_W-1:0];
            result.data_byte   = d;
            result.stored_flag = 1'b1;
            fill_count_in      = fill_count_ff + FILL_W'(1);
            if (fill_count_ff == FILL_W'(1)) begin
               length_word_in = {d, 8'h00};
            end else if (fill_count_ff == FILL_W'(2)) begin
               length_word_in = {length_word_ff[15:8], d};
            end else if (fill_count_ff >= FILL_W'(3)) begin
               if (LENGTH_W'(pay_pos) < length_word_ff) begin
                  payload_sum_in = payload_sum_ff + d;
               end else if (d == (SUM_BASE - payload_sum_ff)) begin
                  good_in = good_ff + COUNT_W'(1);
                  ev      = EV_GOOD;
               end else begin
                  bad_in = bad_ff + COUNT_W'(1);
                  ev     = EV_BAD;
               end
            end
            if (fill_count_ff >= FILL_W'(2)) begin
               result.frame_length = length_word_in;
            end
            if (ev != EV_NONE) begin
               fill_count_in     = '0;
               escape_pending_in = 1'b0;
               length_word_in    = '0;
               payload_sum_in    = '0;
            end
         end
      end

      result.event_res      = ev;
      result.bytes_received = received_in;
      result.bytes_dropped  = discarded_in;
      result.frames_good    = good_in;
      result.frames_bad     = bad_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_count_ff     <= '0;
         escape_pending_ff <= 1'b0;
         length_word_ff    <= '0;
         payload_sum_ff    <= '0;
         received_ff       <= '0;
         discarded_ff      <= '0;
         good_ff           <= '0;
         bad_ff            <= '0;
      end else if (accept) begin
         fill_count_ff     <= fill_count_in;
         escape_pending_ff <= escape_pending_in;
         length_word_ff    <= length_word_in;
         payload_sum_ff    <= payload_sum_in;
         received_ff       <= received_in;
         discarded_ff      <= discarded_in;
         good_ff           <= good_in;
         bad_ff            <= bad_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/efr_skid.sv
// ----------------------------------------------------------------------------
// efr_skid
// Result register with a skid stage so the input keeps flowing while the
// receiver of results stalls, until the skid stage is full.
// ----------------------------------------------------------------------------
`default_nettype none

module efr_skid
   import efr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   input  wire result_type in_data,
   output logic            in_stall,
   output logic            out_valid,
   output result_type      out_data,
   input  wire logic       out_stall
);

   logic       out_valid_ff, skid_valid_ff;
   result_type out_data_ff, skid_data_ff;
   logic       take, load;

   assign take      = out_valid_ff && !out_stall;
   assign load      = in_valid && !skid_valid_ff;
   assign in_stall  = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || take) begin
         if (skid_valid_ff) begin
            out_data_ff   <= skid_data_ff;
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= load;
            if (load) begin
               out_data_ff <= in_data;
            end
         end
      end else if (load) begin
         skid_data_ff  <= in_data;
         skid_valid_ff <= 1'b1;
      end
   end

endmodule

`default_nettype wire

// File: rtl/efr_checker.sv
// ----------------------------------------------------------------------------
// efr_checker
// Port-level checks on the escaped frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module efr_checker
   import efr_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire logic [7:0]          rsp_data_byte,
   input wire logic                rsp_stored_flag,
   input wire logic [INDEX_W-1:0]  rsp_byte_index,
   input wire logic [2:0]          rsp_event_res,
   input wire logic [COUNT_W-1:0]  rsp_bytes_received
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data_byte)
         && $stable(rsp_bytes_received))
      else $error("stalled result beat changed");

   a_unstored_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stored_flag |-> rsp_data_byte == 8'h00 && rsp_byte_index == '0)
      else $error("unstored beat carries data");

   a_event_store: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res == EV_GOOD || rsp_event_res == EV_BAD
         || rsp_event_res == EV_RESTART) |-> rsp_stored_flag)
      else $error("frame event without stored byte");

   a_overflow_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res == EV_OVERFLOW |-> !rsp_stored_flag)
      else $error("overflow beat stored a byte");

endmodule

bind escaped_frame_receiver efr_checker u_efr_checker (.*);

`default_nettype wire
